[hw/rtl/nmea_gga_rmc_sentence_parser_core_macros.svh]
// Assertion macros shared by the NMEA parser RTL.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef NMEA_GGA_RMC_SENTENCE_PARSER_CORE_MACROS_SVH
`define NMEA_GGA_RMC_SENTENCE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NGRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, checked out of reset.
`define NGRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

[hw/rtl/ngrp_pkg.sv]
// Package for the NMEA GGA/RMC parser: character codes, limits, scan helpers.
// No dependencies.
package ngrp_pkg;

  localparam int MAX_LINE = 128;
  localparam int POS_W    = $clog2(MAX_LINE);

  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4d;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // header match codes
  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_GGA  = 2'd1;
  localparam logic [1:0] HDR_RMC  = 2'd2;
  localparam logic [1:0] HDR_OPEN = 2'd3;

  localparam logic [4:0] FLD_FROZEN = 5'd31;
  localparam logic [4:0] FLD_MAX    = 5'd30;
  localparam logic [2:0] PH_END     = 3'd7;
  localparam logic [2:0] FCHAR_MAX  = 3'd7;

  localparam logic [31:0] COORD_CAP   = 32'd268435455;
  localparam logic [26:0] LAT_MAX     = 27'd54000000;
  localparam logic [27:0] LON_MAX     = 28'd108000000;
  localparam logic [23:0] ALT_POS_MAX = 24'd999999;
  localparam logic [20:0] ALT_NEG_MAX = 21'd99999;
  localparam logic [19:0] SPEED_MAX   = 20'd99999;
  localparam logic [31:0] DEG_SCALE   = 32'd400000;   // 1e6 - 600000
  localparam logic [20:0] MPH_MUL     = 21'd1150779;
  localparam logic [31:0] MPH_RECIP   = 32'd2251799814; // ceil(2^45 / 15625)
  localparam int          MPH_SHIFT   = 45;

  // number scan result: hit = digit taken, idx 0 = integer, k = k-th fraction
  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
    logic [2:0] ph;
  } scan_t;

  // coordinate accumulator: raw ddmm.mmmm x 1e4, plus degrees and the two
  // low integer digits so minutes can be split off without a divider
  typedef struct packed {
    logic [27:0] raw;
    logic [8:0]  deg;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic        sat;
  } coord_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic scan_t scan_char(logic [7:0] c, logic [2:0] ph);
    scan_t s;
    s.hit = 1'b0;
    s.idx = ph;
    s.ph  = ph;
    if (ph == PH_END) begin
      s.ph = PH_END;
    end else if (c == CH_DOT) begin
      s.ph = (ph == 3'd0) ? 3'd1 : PH_END;
    end else if (!is_digit(c)) begin
      s.ph = PH_END;
    end else begin
      s.hit = 1'b1;
      if (ph != 3'd0 && ph < 3'd6) s.ph = ph + 3'd1;
    end
    return s;
  endfunction

  function automatic coord_t coord_step(coord_t cur, scan_t s, logic [3:0] d);
    coord_t      n;
    logic [31:0] sum;
    logic [31:0] step;
    logic [11:0] deg_w;
    n     = cur;
    sum   = {4'd0, cur.raw};
    step  = 32'd0;
    deg_w = 12'd10 * {3'd0, cur.deg} + {8'd0, cur.tens};
    unique case (s.idx)
      3'd1:    step = 32'd1000;
      3'd2:    step = 32'd100;
      3'd3:    step = 32'd10;
      3'd4:    step = 32'd1;
      default: step = 32'd0;
    endcase
    if (s.hit && s.idx == 3'd0) begin
      sum    = {4'd0, cur.raw} * 32'd10 + {28'd0, d} * 32'd10000;
      n.deg  = deg_w[8:0];
      n.tens = cur.ones;
      n.ones = d;
    end else if (s.hit) begin
      sum = {4'd0, cur.raw} + {28'd0, d} * step;
    end
    if (sum > COORD_CAP) begin
      n.raw = COORD_CAP[27:0];
      n.sat = 1'b1;
    end else begin
      n.raw = sum[27:0];
    end
    return n;
  endfunction

  // first result stage: snapshot of the line
  typedef struct packed {
    logic        kind;
    coord_t      lat;
    coord_t      lon;
    logic        lat_neg;
    logic        lon_neg;
    logic [3:0]  qual;
    logic [6:0]  sats;
    logic [20:0] alt;
    logic        alt_neg;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic [16:0] spd;
    logic        fixv;
  } stg1_t;

  // second result stage: minutes folded, speed product formed
  typedef struct packed {
    logic        kind;
    logic [26:0] lat_v;
    logic [27:0] lon_v;
    logic        lat_neg;
    logic        lon_neg;
    logic [3:0]  qual;
    logic [6:0]  sats;
    logic [20:0] alt_v;
    logic        alt_neg;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic [16:0] spd;
    logic [36:0] prod;
    logic        fixv;
  } stg2_t;

endpackage

[hw/rtl/nmea_gga_rmc_sentence_parser_core.sv]
// NMEA GGA/RMC sentence parser, top level.
// Depends on ngrp_pkg and nmea_gga_rmc_sentence_parser_core_macros.svh.
//
// Usage:
//   in_*  : one received byte per request (valid/ready). A byte is taken
//           every cycle while the result pipe has room.
//   out_* : one request per completed $GNGGA or $GNRMC line (valid/ready).
//           Other lines, empty lines and over-long lines produce nothing.
// Pipeline: the snapshot is taken at the edge that accepts the CR/LF byte,
//   then the minute fold and speed product, then the reciprocal multiply
//   into the output register.
// Throughput: 1 byte per cycle while in_ready is high; the field accumulators
//   update in the same cycle the byte is taken.
// Stall: a result waiting at the output does not stop input; in_ready drops
//   only when all three result stages hold requests and out_ready is low.
// Reset: rst_n (synchronous, active low) empties the result pipe and clears
//   the line state, as if no byte had been received.
module nmea_gga_rmc_sentence_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_sentence_kind,
  output logic signed [26:0]  out_latitude,
  output logic signed [27:0]  out_longitude,
  output logic [3:0]          out_fix_quality,
  output logic [6:0]          out_satellites,
  output logic signed [20:0]  out_altitude_dm,
  output logic [6:0]          out_hour,
  output logic [6:0]          out_minute,
  output logic [6:0]          out_second,
  output logic [16:0]         out_speed_knots_centi,
  output logic [16:0]         out_speed_mph_centi,
  output logic                out_fix_valid
);

`include "nmea_gga_rmc_sentence_parser_core_macros.svh"

  // line state
  logic [ngrp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]                 hdr_r, hdr_nxt;
  logic [4:0]                 fnum_r, fnum_nxt;
  logic [2:0]                 fchar_r, fchar_nxt;
  logic [2:0]                 frac_r, frac_nxt;
  ngrp_pkg::coord_t           lat_r, lat_nxt, lon_r, lon_nxt;
  logic [20:0]                alt_r, alt_nxt;
  logic [16:0]                spd_r, spd_nxt;
  logic [6:0]                 tm0_r, tm0_nxt, tm1_r, tm1_nxt, tm2_r, tm2_nxt;
  logic [2:0]                 stop_r, stop_nxt;
  logic [3:0]                 qual_r, qual_nxt;
  logic [6:0]                 sats_r, sats_nxt;
  logic [3:0]                 flags_r, flags_nxt;

  // result pipe
  logic                       s1_valid_r, s2_valid_r, out_valid_r;
  ngrp_pkg::stg1_t            s1_r, s1_nxt;
  ngrp_pkg::stg2_t            s2_r, s2_nxt;

  logic                       in_fire, is_end, emit, clr;
  logic                       out_free, s2_free, s1_free;
  logic [7:0]                 c;
  logic [3:0]                 d;
  ngrp_pkg::scan_t            sc;
  logic [6:0]                 qual_w;
  logic [9:0]                 sats_w;
  logic [23:0]                alt_w;
  logic [19:0]                spd_w;
  logic [6:0]                 tm_w;
  logic [1:0]                 pair;

  // handshake and pipe advance
  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign c      = in_rx_byte;
  assign d      = 4'(c - ngrp_pkg::CH_0);
  assign sc     = ngrp_pkg::scan_char(c, frac_r);
  assign is_end = (c == ngrp_pkg::CH_LF) || (c == ngrp_pkg::CH_CR);
  assign emit   = is_end && (pos_r >= ngrp_pkg::POS_W'(6)) &&
                  (hdr_r == ngrp_pkg::HDR_GGA || hdr_r == ngrp_pkg::HDR_RMC);
  assign pair   = fchar_r[2:1];

  // per-byte line parsing
  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    fnum_nxt  = fnum_r;
    fchar_nxt = fchar_r;
    frac_nxt  = frac_r;
    lat_nxt   = lat_r;
    lon_nxt   = lon_r;
    alt_nxt   = alt_r;
    spd_nxt   = spd_r;
    tm0_nxt   = tm0_r;
    tm1_nxt   = tm1_r;
    tm2_nxt   = tm2_r;
    stop_nxt  = stop_r;
    qual_nxt  = qual_r;
    sats_nxt  = sats_r;
    flags_nxt = flags_r;
    clr       = 1'b0;
    qual_w    = 7'd10 * {3'd0, qual_r} + {3'd0, d};
    sats_w    = 10'd10 * {3'd0, sats_r} + {6'd0, d};
    alt_w     = 24'd0;
    spd_w     = 20'd0;
    tm_w      = 7'd0;

    if (in_fire) begin
      if (is_end) begin
        clr = (pos_r != '0);
      end else if (pos_r >= ngrp_pkg::POS_W'(ngrp_pkg::MAX_LINE - 1)) begin
        clr = 1'b1;
      end else begin
        pos_nxt = pos_r + ngrp_pkg::POS_W'(1);
        if (pos_r < ngrp_pkg::POS_W'(6)) begin
          // header "$GNGGA" / "$GNRMC"
          priority if (pos_r == ngrp_pkg::POS_W'(0)) begin
            hdr_nxt = (c == ngrp_pkg::CH_DOLLAR) ? ngrp_pkg::HDR_OPEN : ngrp_pkg::HDR_NONE;
          end else if (pos_r == ngrp_pkg::POS_W'(1)) begin
            if (c != ngrp_pkg::CH_G) hdr_nxt = ngrp_pkg::HDR_NONE;
          end else if (pos_r == ngrp_pkg::POS_W'(2)) begin
            if (c != ngrp_pkg::CH_N) hdr_nxt = ngrp_pkg::HDR_NONE;
          end else if (pos_r == ngrp_pkg::POS_W'(3)) begin
            if (hdr_r == ngrp_pkg::HDR_OPEN && c == ngrp_pkg::CH_G) hdr_nxt = ngrp_pkg::HDR_GGA;
            else if (hdr_r == ngrp_pkg::HDR_OPEN && c == ngrp_pkg::CH_R)
              hdr_nxt = ngrp_pkg::HDR_RMC;
            else hdr_nxt = ngrp_pkg::HDR_NONE;
          end else if (pos_r == ngrp_pkg::POS_W'(4)) begin
            if (!((hdr_r == ngrp_pkg::HDR_GGA && c == ngrp_pkg::CH_G) ||
                  (hdr_r == ngrp_pkg::HDR_RMC && c == ngrp_pkg::CH_M)))
              hdr_nxt = ngrp_pkg::HDR_NONE;
          end else begin
            if (!((hdr_r == ngrp_pkg::HDR_GGA && c == ngrp_pkg::CH_A) ||
                  (hdr_r == ngrp_pkg::HDR_RMC && c == ngrp_pkg::CH_C)))
              hdr_nxt = ngrp_pkg::HDR_NONE;
          end
        end else if (fnum_r != ngrp_pkg::FLD_FROZEN) begin
          if (c == ngrp_pkg::CH_NUL) begin
            fnum_nxt = ngrp_pkg::FLD_FROZEN;
          end else if (c == ngrp_pkg::CH_COMMA) begin
            if (fnum_r < ngrp_pkg::FLD_MAX) fnum_nxt = fnum_r + 5'd1;
            fchar_nxt = 3'd0;
            frac_nxt  = 3'd0;
          end else begin
            if (fchar_r < ngrp_pkg::FCHAR_MAX) fchar_nxt = fchar_r + 3'd1;
            if (hdr_r == ngrp_pkg::HDR_GGA) begin
              // GGA fields
              unique case (fnum_r)
                5'd2: begin
                  frac_nxt = sc.ph;
                  lat_nxt  = ngrp_pkg::coord_step(lat_r, sc, d);
                end
                5'd3: begin
                  if (fchar_r == 3'd0 && (c == ngrp_pkg::CH_S || c == ngrp_pkg::CH_W))
                    flags_nxt[0] = 1'b1;
                end
                5'd4: begin
                  frac_nxt = sc.ph;
                  lon_nxt  = ngrp_pkg::coord_step(lon_r, sc, d);
                end
                5'd5: begin
                  if (fchar_r == 3'd0 && (c == ngrp_pkg::CH_S || c == ngrp_pkg::CH_W))
                    flags_nxt[1] = 1'b1;
                end
                5'd6: begin
                  frac_nxt = sc.ph;
                  if (sc.hit && sc.idx == 3'd0)
                    qual_nxt = (qual_w > 7'd9) ? 4'd9 : qual_w[3:0];
                end
                5'd7: begin
                  frac_nxt = sc.ph;
                  if (sc.hit && sc.idx == 3'd0)
                    sats_nxt = (sats_w > 10'd99) ? 7'd99 : sats_w[6:0];
                end
                5'd9: begin
                  if (fchar_r == 3'd0 && c == ngrp_pkg::CH_MINUS) begin
                    flags_nxt[3] = 1'b1;
                  end else begin
                    frac_nxt = sc.ph;
                    if (sc.hit && sc.idx == 3'd0)
                      alt_w = 24'd10 * {3'd0, alt_r} + 24'd10 * {20'd0, d};
                    else if (sc.hit && sc.idx == 3'd1)
                      alt_w = {3'd0, alt_r} + {20'd0, d};
                    else
                      alt_w = {3'd0, alt_r};
                    alt_nxt = (alt_w > ngrp_pkg::ALT_POS_MAX) ?
                              ngrp_pkg::ALT_POS_MAX[20:0] : alt_w[20:0];
                  end
                end
                default: begin
                end
              endcase
            end else if (hdr_r == ngrp_pkg::HDR_RMC) begin
              // RMC fields
              unique case (fnum_r)
                5'd1: begin
                  if (fchar_r < 3'd6 && !stop_r[pair]) begin
                    if (ngrp_pkg::is_digit(c)) begin
                      unique case (pair)
                        2'd0:    tm_w = 7'd10 * tm0_r + {3'd0, d};
                        2'd1:    tm_w = 7'd10 * tm1_r + {3'd0, d};
                        default: tm_w = 7'd10 * tm2_r + {3'd0, d};
                      endcase
                      unique case (pair)
                        2'd0:    tm0_nxt = tm_w;
                        2'd1:    tm1_nxt = tm_w;
                        default: tm2_nxt = tm_w;
                      endcase
                    end else begin
                      stop_nxt[pair] = 1'b1;
                    end
                  end
                end
                5'd2: begin
                  if (fchar_r == 3'd0 && c == ngrp_pkg::CH_A) flags_nxt[2] = 1'b1;
                end
                5'd7: begin
                  frac_nxt = sc.ph;
                  if (sc.hit && sc.idx == 3'd0)
                    spd_w = 20'd10 * {3'd0, spd_r} + 20'd100 * {16'd0, d};
                  else if (sc.hit && sc.idx == 3'd1)
                    spd_w = {3'd0, spd_r} + 20'd10 * {16'd0, d};
                  else if (sc.hit && sc.idx == 3'd2)
                    spd_w = {3'd0, spd_r} + {16'd0, d};
                  else
                    spd_w = {3'd0, spd_r};
                  spd_nxt = (spd_w > ngrp_pkg::SPEED_MAX) ?
                            ngrp_pkg::SPEED_MAX[16:0] : spd_w[16:0];
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    end

    // end of line or overflow: start an empty line
    if (clr) begin
      pos_nxt   = '0;
      hdr_nxt   = ngrp_pkg::HDR_NONE;
      fnum_nxt  = 5'd0;
      fchar_nxt = 3'd0;
      frac_nxt  = 3'd0;
      lat_nxt   = '0;
      lon_nxt   = '0;
      alt_nxt   = 21'd0;
      spd_nxt   = 17'd0;
      tm0_nxt   = 7'd0;
      tm1_nxt   = 7'd0;
      tm2_nxt   = 7'd0;
      stop_nxt  = 3'd0;
      qual_nxt  = 4'd0;
      sats_nxt  = 7'd0;
      flags_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hdr_r   <= ngrp_pkg::HDR_NONE;
      fnum_r  <= 5'd0;
      fchar_r <= 3'd0;
      frac_r  <= 3'd0;
      lat_r   <= '0;
      lon_r   <= '0;
      alt_r   <= 21'd0;
      spd_r   <= 17'd0;
      tm0_r   <= 7'd0;
      tm1_r   <= 7'd0;
      tm2_r   <= 7'd0;
      stop_r  <= 3'd0;
      qual_r  <= 4'd0;
      sats_r  <= 7'd0;
      flags_r <= 4'd0;
    end else begin
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      fnum_r  <= fnum_nxt;
      fchar_r <= fchar_nxt;
      frac_r  <= frac_nxt;
      lat_r   <= lat_nxt;
      lon_r   <= lon_nxt;
      alt_r   <= alt_nxt;
      spd_r   <= spd_nxt;
      tm0_r   <= tm0_nxt;
      tm1_r   <= tm1_nxt;
      tm2_r   <= tm2_nxt;
      stop_r  <= stop_nxt;
      qual_r  <= qual_nxt;
      sats_r  <= sats_nxt;
      flags_r <= flags_nxt;
    end
  end

  // stage 1: snapshot of the finished line
  always_comb begin
    s1_nxt.kind    = (hdr_r == ngrp_pkg::HDR_RMC);
    s1_nxt.lat     = lat_r;
    s1_nxt.lon     = lon_r;
    s1_nxt.lat_neg = flags_r[0];
    s1_nxt.lon_neg = flags_r[1];
    s1_nxt.fixv    = flags_r[2];
    s1_nxt.alt_neg = flags_r[3];
    s1_nxt.qual    = qual_r;
    s1_nxt.sats    = sats_r;
    s1_nxt.alt     = alt_r;
    s1_nxt.hh      = tm0_r;
    s1_nxt.mm      = tm1_r;
    s1_nxt.ss      = tm2_r;
    s1_nxt.spd     = spd_r;
  end

  // stage 2: fold degrees to minutes (raw - 400000*deg), cap, speed product
  logic [31:0] lat_fold, lon_fold;
  assign lat_fold = {4'd0, s1_r.lat.raw} - {23'd0, s1_r.lat.deg} * ngrp_pkg::DEG_SCALE;
  assign lon_fold = {4'd0, s1_r.lon.raw} - {23'd0, s1_r.lon.deg} * ngrp_pkg::DEG_SCALE;

  always_comb begin
    s2_nxt.kind    = s1_r.kind;
    s2_nxt.lat_neg = s1_r.lat_neg;
    s2_nxt.lon_neg = s1_r.lon_neg;
    s2_nxt.qual    = s1_r.qual;
    s2_nxt.sats    = s1_r.sats;
    s2_nxt.alt_neg = s1_r.alt_neg;
    s2_nxt.hh      = s1_r.hh;
    s2_nxt.mm      = s1_r.mm;
    s2_nxt.ss      = s1_r.ss;
    s2_nxt.spd     = s1_r.spd;
    s2_nxt.fixv    = s1_r.fixv;
    if (s1_r.lat.sat || lat_fold > {5'd0, ngrp_pkg::LAT_MAX}) s2_nxt.lat_v = ngrp_pkg::LAT_MAX;
    else s2_nxt.lat_v = lat_fold[26:0];
    if (s1_r.lon.sat || lon_fold > {4'd0, ngrp_pkg::LON_MAX}) s2_nxt.lon_v = ngrp_pkg::LON_MAX;
    else s2_nxt.lon_v = lon_fold[27:0];
    if (s1_r.alt_neg && s1_r.alt > ngrp_pkg::ALT_NEG_MAX) s2_nxt.alt_v = ngrp_pkg::ALT_NEG_MAX;
    else s2_nxt.alt_v = s1_r.alt;
    s2_nxt.prod = 37'({20'd0, s1_r.spd} * {16'd0, ngrp_pkg::MPH_MUL});
  end

  // stage 3: signs, mph by reciprocal, zero the other kind's fields
  logic [63:0] mph_prod;
  assign mph_prod = {33'd0, s2_r.prod[36:6]} * {32'd0, ngrp_pkg::MPH_RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_free ? (in_fire && emit) : 1'b1;
      s2_valid_r  <= s2_free ? s1_valid_r : 1'b1;
      out_valid_r <= out_free ? s2_valid_r : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) s1_r <= s1_nxt;
    if (s2_free) s2_r <= s2_nxt;
    if (out_free) begin
      out_sentence_kind <= s2_r.kind;
      if (!s2_r.kind) begin
        out_latitude          <= s2_r.lat_neg ? -$signed(s2_r.lat_v) : $signed(s2_r.lat_v);
        out_longitude         <= s2_r.lon_neg ? -$signed(s2_r.lon_v) : $signed(s2_r.lon_v);
        out_fix_quality       <= s2_r.qual;
        out_satellites        <= s2_r.sats;
        out_altitude_dm       <= s2_r.alt_neg ? -$signed(s2_r.alt_v) : $signed(s2_r.alt_v);
        out_hour              <= 7'd0;
        out_minute            <= 7'd0;
        out_second            <= 7'd0;
        out_speed_knots_centi <= 17'd0;
        out_speed_mph_centi   <= 17'd0;
        out_fix_valid         <= 1'b0;
      end else begin
        out_latitude          <= 27'sd0;
        out_longitude         <= 28'sd0;
        out_fix_quality       <= 4'd0;
        out_satellites        <= 7'd0;
        out_altitude_dm       <= 21'sd0;
        out_hour              <= s2_r.hh;
        out_minute            <= s2_r.mm;
        out_second            <= s2_r.ss;
        out_speed_knots_centi <= s2_r.spd;
        out_speed_mph_centi   <= 17'(mph_prod >> ngrp_pkg::MPH_SHIFT);
        out_fix_valid         <= s2_r.fixv;
      end
    end
  end

  // checks
  `NGRP_ASSERT_NOW(a_ready_only_when_full, !in_ready,
    s1_valid_r && s2_valid_r && out_valid_r && !out_ready)
  `NGRP_ASSERT_NEXT(a_emit_enters_pipe, in_fire && emit, s1_valid_r)
  `NGRP_ASSERT_NEXT(a_line_end_clears, in_fire && is_end, pos_r == '0)
  `NGRP_ASSERT_NOW(a_pos_bound, 1'b1,
    pos_r <= ngrp_pkg::POS_W'(ngrp_pkg::MAX_LINE - 1))
  `NGRP_ASSERT_NOW(a_gga_has_no_rmc, out_valid_r && !out_sentence_kind,
    !out_fix_valid && out_hour == 7'd0 && out_speed_knots_centi == 17'd0)

endmodule
